[hw/rtl/bdq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    // Request codes carried in the func field.
    localparam logic [2:0] F_PUSH_FRONT = 3'd0;
    localparam logic [2:0] F_PUSH_BACK  = 3'd1;
    localparam logic [2:0] F_POP_FRONT  = 3'd2;
    localparam logic [2:0] F_POP_BACK   = 3'd3;
    localparam logic [2:0] F_REMOVE     = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Field widths of the stream payloads.
    localparam int FUNC_W  = 3;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Work a token does as it walks the cell row.
    typedef enum logic [2:0] {
        MD_NONE,
        MD_PUSH_F,
        MD_PUSH_B,
        MD_POP_F,
        MD_POP_B,
        MD_REMOVE
    } t_mode;

    // Request token handed from cell to cell, one cell per clock.
    typedef struct packed {
        logic              active;
        logic              live;
        logic              found;
        t_mode             mode;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] carry;
        logic [DATA_W-1:0] popped;
    } t_tok;

endpackage

`default_nettype wire

[hw/rtl/bounded_deque_with_remove_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Each request travels as a token through the row of DEPTH cells, one cell
// per clock; its result is registered when the token leaves the last cell, or
// held until the output register is free. The next request is taken in the
// cycle after the token leaves the last cell, later if a result waits.
// Reset (synchronous, active low) empties the sequence and clears all handshake
// state; stored entries keep no reset value and are read only after a write.
module bounded_deque_with_remove_core #(
    parameter int DEPTH = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [2:0] func, [34:3] operand_value, [39:35] zero
    input  wire  [bdq_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // [31:0] popped_value, [33:32] status, [38:34] entry_count, [39] zero
    output logic [bdq_pkg::M_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_HOLD
    } t_state;

    t_state                          r_state;
    logic [CW-1:0]                   r_count;
    logic [2:0]                      r_func;
    logic [bdq_pkg::STAT_W-1:0]      r_pre_status;
    logic                            r_out_valid;
    logic [bdq_pkg::DATA_W-1:0]      r_out_popped;
    logic [bdq_pkg::STAT_W-1:0]      r_out_status;
    logic [CW-1:0]                   r_out_count;
    logic [bdq_pkg::DATA_W-1:0]      r_pend_popped;
    logic [bdq_pkg::STAT_W-1:0]      r_pend_status;
    logic [CW-1:0]                   r_pend_count;

    bdq_pkg::t_tok                   w_tok   [0:DEPTH];
    logic [CW-1:0]                   w_rem   [0:DEPTH];
    logic [bdq_pkg::DATA_W-1:0]      w_entry [0:DEPTH-1];

    logic                            in_acc;
    logic [2:0]                      in_func;
    logic [bdq_pkg::DATA_W-1:0]      in_value;
    logic                            is_full;
    logic                            is_empty;
    bdq_pkg::t_mode                  l_mode;
    logic                            l_live;
    logic [bdq_pkg::STAT_W-1:0]      l_status;
    logic                            tok_exit;
    logic [bdq_pkg::STAT_W-1:0]      x_status;
    logic [CW-1:0]                   x_count;
    logic                            out_free;
    logic                            out_load;

    assign in_func  = i_s_axis_tdata[2:0];
    assign in_value = i_s_axis_tdata[34:3];
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign is_full  = (r_count == DEPTH_C);
    assign is_empty = (r_count == '0);
    assign o_s_axis_tready = i_rst_n && (r_state == S_IDLE);

    // Decode the request into the token's work and the status known up front.
    always_comb begin
        l_mode   = bdq_pkg::MD_NONE;
        l_live   = 1'b0;
        l_status = bdq_pkg::ST_OK;
        case (in_func)
            bdq_pkg::F_PUSH_FRONT: begin
                l_mode   = bdq_pkg::MD_PUSH_F;
                l_live   = !is_full;
                l_status = is_full ? bdq_pkg::ST_FULL : bdq_pkg::ST_OK;
            end
            bdq_pkg::F_PUSH_BACK: begin
                l_mode   = bdq_pkg::MD_PUSH_B;
                l_live   = !is_full;
                l_status = is_full ? bdq_pkg::ST_FULL : bdq_pkg::ST_OK;
            end
            bdq_pkg::F_POP_FRONT: begin
                l_mode   = bdq_pkg::MD_POP_F;
                l_live   = !is_empty;
                l_status = is_empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
            end
            bdq_pkg::F_POP_BACK: begin
                l_mode   = bdq_pkg::MD_POP_B;
                l_live   = !is_empty;
                l_status = is_empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
            end
            bdq_pkg::F_REMOVE: begin
                l_mode   = bdq_pkg::MD_REMOVE;
                l_live   = 1'b1;
                l_status = bdq_pkg::ST_OK;
            end
            default: begin
            end
        endcase
    end

    // Token launched into the first cell on the accepting edge.
    assign w_tok[0].active = in_acc;
    assign w_tok[0].live   = in_acc && l_live;
    assign w_tok[0].found  = 1'b0;
    assign w_tok[0].mode   = l_mode;
    assign w_tok[0].value  = in_value;
    assign w_tok[0].carry  = in_value;
    assign w_tok[0].popped = '0;
    assign w_rem[0]        = r_count;

    // Row of cells; each cell shifts toward a neighbor as the token passes.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [bdq_pkg::DATA_W-1:0] next_entry;
        if (g == DEPTH - 1) begin : g_last
            assign next_entry = w_entry[g];
        end else begin : g_mid
            assign next_entry = w_entry[g + 1];
        end
        bdq_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_tok        (w_tok[g]),
            .i_rem        (w_rem[g]),
            .i_next_entry (next_entry),
            .o_entry      (w_entry[g]),
            .o_tok        (w_tok[g + 1]),
            .o_rem        (w_rem[g + 1])
        );
    end

    // Final status and occupancy once the token leaves the row.
    assign tok_exit = w_tok[DEPTH].active;
    always_comb begin
        x_status = r_pre_status;
        x_count  = r_count;
        if ((r_func == bdq_pkg::F_REMOVE) && !w_tok[DEPTH].found) begin
            x_status = bdq_pkg::ST_NOTFOUND;
        end
        if (r_pre_status == bdq_pkg::ST_OK) begin
            case (r_func)
                bdq_pkg::F_PUSH_FRONT,
                bdq_pkg::F_PUSH_BACK:  x_count = r_count + CW'(1);
                bdq_pkg::F_POP_FRONT,
                bdq_pkg::F_POP_BACK:   x_count = r_count - CW'(1);
                bdq_pkg::F_REMOVE: begin
                    if (w_tok[DEPTH].found) begin
                        x_count = r_count - CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    // The output register takes a new result when the row or the hold stage
    // delivers one and the register is free.
    assign out_load = out_free &&
                      (((r_state == S_BUSY) && tok_exit) || (r_state == S_HOLD));

    // Sequencer, occupancy and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_func       <= in_func;
                        r_pre_status <= l_status;
                        r_state      <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    if (tok_exit) begin
                        r_count <= x_count;
                        if (out_free) begin
                            r_out_popped <= w_tok[DEPTH].popped;
                            r_out_status <= x_status;
                            r_out_count  <= x_count;
                            r_state      <= S_IDLE;
                        end else begin
                            r_pend_popped <= w_tok[DEPTH].popped;
                            r_pend_status <= x_status;
                            r_pend_count  <= x_count;
                            r_state       <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out_popped <= r_pend_popped;
                        r_out_status <= r_pend_status;
                        r_out_count  <= r_pend_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, bdq_pkg::CNT_W'(r_out_count), r_out_status, r_out_popped};

    // A token leaves the row only while a request is in flight.
    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_exit |-> (r_state == S_BUSY))
        else $error("token left the cell row with no request in flight");

    // Occupancy never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("occupancy above capacity");

    // A rejected push or pop leaves the occupancy unchanged.
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok_exit && ((r_pre_status == bdq_pkg::ST_FULL) ||
                      (r_pre_status == bdq_pkg::ST_EMPTY))) |=> $stable(r_count))
        else $error("rejected request changed occupancy");

    // An accepted request is not followed by another until its token exits.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready)
        else $error("second request accepted while one is in flight");

endmodule

`default_nettype wire

[hw/rtl/bdq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell #(
    parameter int CW = 5
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire  bdq_pkg::t_tok             i_tok,
    input  wire  [CW-1:0]                   i_rem,
    input  wire  [bdq_pkg::DATA_W-1:0]      i_next_entry,
    output logic [bdq_pkg::DATA_W-1:0]      o_entry,
    output bdq_pkg::t_tok                   o_tok,
    output logic [CW-1:0]                   o_rem
);

    logic [bdq_pkg::DATA_W-1:0] r_entry;
    logic [bdq_pkg::DATA_W-1:0] n_entry;
    bdq_pkg::t_tok              r_tok;
    bdq_pkg::t_tok              n_tok;
    logic [CW-1:0]              r_rem;
    logic [CW-1:0]              n_rem;

    // Act on the token that sits at this cell; i_rem counts stored entries
    // from this cell to the back of the sequence.
    always_comb begin
        n_entry = r_entry;
        n_tok   = i_tok;
        n_rem   = i_rem;
        if (i_tok.active && i_tok.live) begin
            if (i_rem != '0) begin
                n_rem = i_rem - CW'(1);
                case (i_tok.mode)
                    bdq_pkg::MD_PUSH_F: begin
                        n_entry     = i_tok.carry;
                        n_tok.carry = r_entry;
                    end
                    bdq_pkg::MD_POP_F: begin
                        if (!i_tok.found) begin
                            n_tok.popped = r_entry;
                        end
                        n_tok.found = 1'b1;
                        n_entry     = i_next_entry;
                    end
                    bdq_pkg::MD_REMOVE: begin
                        if (i_tok.found || (r_entry == i_tok.value)) begin
                            n_tok.found = 1'b1;
                            n_entry     = i_next_entry;
                        end
                    end
                    bdq_pkg::MD_POP_B: begin
                        if (i_rem == CW'(1)) begin
                            n_tok.popped = r_entry;
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                // First cell past the back: finish the request here.
                n_tok.live = 1'b0;
                case (i_tok.mode)
                    bdq_pkg::MD_PUSH_F: n_entry = i_tok.carry;
                    bdq_pkg::MD_PUSH_B: n_entry = i_tok.value;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Entry storage needs no reset; the token stage does.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_rem   <= n_rem;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_entry = r_entry;
    assign o_tok   = r_tok;
    assign o_rem   = r_rem;

endmodule

`default_nettype wire

[dv/bounded_deque_with_remove_core_test.sv]
`timescale 1ns / 1ps

module bounded_deque_with_remove_core_test;
    import bdq_pkg::*;

    localparam int DEPTH = 16;
    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 1020;

    // Function codes the block must ignore.
    localparam logic [2:0] F_SPARE_5 = 3'd5;
    localparam logic [2:0] F_SPARE_6 = 3'd6;
    localparam logic [2:0] F_SPARE_7 = 3'd7;

    // One result as the block reports it.
    typedef struct packed {
        logic [DATA_W-1:0] popped;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
    } t_result;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data = '0;
    logic                 m_ready = 1'b0;
    wire                  s_ready;
    wire                  m_valid;
    wire  [M_TDATA_W-1:0] m_data;

    // Shadow copy of the stored sequence, front at index 0.
    logic [DATA_W-1:0] deque_model[$];
    // Results still owed by the block, oldest first.
    t_result expected_results[$];

    int error_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_cycle = 0;
    int stall_mode = 0;

    always #4 clk = ~clk;

    bounded_deque_with_remove_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    // Apply one request to the shadow sequence and return the result it owes.
    function automatic t_result apply_request(input logic [2:0] func,
                                              input logic [DATA_W-1:0] value);
        t_result r;
        int hit;
        r.popped = '0;
        r.status = ST_OK;
        r.count = '0;
        hit = -1;
        case (func)
            F_PUSH_FRONT, F_PUSH_BACK: begin
                if (deque_model.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (func == F_PUSH_FRONT) begin
                    deque_model.push_front(value);
                end else begin
                    deque_model.push_back(value);
                end
            end
            F_POP_FRONT: begin
                if (deque_model.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped = deque_model.pop_front();
                end
            end
            F_POP_BACK: begin
                if (deque_model.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped = deque_model.pop_back();
                end
            end
            F_REMOVE: begin
                // Only the first match counted from the front goes away.
                for (int i = 0; i < deque_model.size() && hit < 0; i++) begin
                    if (deque_model[i] == value) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    deque_model.delete(hit);
                end
            end
            default: begin
            end
        endcase
        r.count = CNT_W'(deque_model.size());
        return r;
    endfunction

    // Present one request, in bursts with random gaps, and wait for acceptance.
    task automatic send_request(input logic [2:0] func, input logic [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_valid <= 1'b1;
        s_data <= {5'b0, value, func};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        expected_results.push_back(apply_request(func, value));
        burst_left--;
    endtask

    // Pops and removes on an empty sequence, and the ignored function codes.
    task automatic test_empty_requests();
        send_request(F_POP_FRONT, 32'hFFFF_FFFF);
        send_request(F_POP_BACK, 32'h0000_0000);
        send_request(F_REMOVE, 32'h0000_0000);
        send_request(F_SPARE_5, 32'h1234_5678);
        send_request(F_SPARE_6, 32'hFFFF_FFFF);
        send_request(F_SPARE_7, 32'h8000_0000);
    endtask

    // Most negative, most positive, zero and minus one pass through both ends.
    task automatic test_extreme_values();
        send_request(F_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(F_PUSH_BACK, 32'h8000_0000);
        send_request(F_PUSH_FRONT, 32'h0000_0000);
        send_request(F_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(F_POP_FRONT, 32'h0000_0000);
        send_request(F_POP_BACK, 32'h0000_0000);
    endtask

    // Fill with repeating values, then push at both ends while full.
    task automatic test_full_queue();
        while (deque_model.size() < DEPTH) begin
            send_request(F_PUSH_BACK, DATA_W'(deque_model.size() % 4));
        end
        send_request(F_PUSH_FRONT, 32'h5555_5555);
        send_request(F_PUSH_BACK, 32'hAAAA_AAAA);
    endtask

    // Duplicates are removed front first; a missing value reports not found.
    task automatic test_duplicate_remove();
        send_request(F_REMOVE, 32'h0000_0002);
        send_request(F_REMOVE, 32'h0000_0002);
        send_request(F_REMOVE, 32'h0000_0063);
        send_request(F_POP_BACK, 32'h0000_0000);
    endtask

    // Random traffic in phases that lean toward filling or draining.
    task automatic test_random_traffic();
        int push_pct;
        int pick;
        logic [2:0] func;
        logic [DATA_W-1:0] value;
        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 25;
                    1: push_pct = 50;
                    default: push_pct = 80;
                endcase
            end
            pick = $urandom_range(0, 99);
            value = $urandom;
            if (pick < 2) begin
                case ($urandom_range(0, 2))
                    0: func = F_SPARE_5;
                    1: func = F_SPARE_6;
                    default: func = F_SPARE_7;
                endcase
            end else if ($urandom_range(0, 99) < 20) begin
                func = F_REMOVE;
                // Mostly search for something that is stored.
                if (deque_model.size() > 0 && $urandom_range(0, 9) < 7) begin
                    value = deque_model[$urandom_range(0, deque_model.size() - 1)];
                end
            end else if ($urandom_range(0, 99) < push_pct) begin
                func = $urandom_range(0, 1) ? F_PUSH_FRONT : F_PUSH_BACK;
                // A small value pool makes duplicates common.
                case ($urandom_range(0, 9))
                    0: value = 32'h8000_0000;
                    1: value = 32'h7FFF_FFFF;
                    2, 3, 4: value = DATA_W'($urandom_range(0, 7));
                    default: value = $urandom;
                endcase
            end else begin
                func = $urandom_range(0, 1) ? F_POP_FRONT : F_POP_BACK;
            end
            send_request(func, value);
        end
    endtask

    // Receiver readiness follows a pattern that is picked anew at intervals.
    always @(posedge clk) begin
        if (stall_cycle % 200 == 0) begin
            stall_mode = $urandom_range(0, 2);
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ((stall_cycle % 23) >= 17);
        endcase
        stall_cycle++;
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            got.popped = m_data[31:0];
            got.status = m_data[33:32];
            got.count = m_data[38:34];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result popped=%h status=%0d count=%0d",
                         $time, got.popped, got.status, got.count);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.popped !== want.popped) begin
                    $display("%0t: popped_value expected %h actual %h",
                             $time, want.popped, got.popped);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    error_count++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, got.count);
                    error_count++;
                end
            end
        end
    end

    // Stop the run when neither side moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[bounded_deque_with_remove_core] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_requests();
        test_extreme_values();
        test_full_queue();
        test_duplicate_remove();
        test_random_traffic();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        // Leave room for any stray result to show up.
        repeat (2 * DEPTH + 4) @(posedge clk);
        if (error_count == 0) begin
            $display("[bounded_deque_with_remove_core] OK");
        end else begin
            $display("[bounded_deque_with_remove_core] ERROR");
        end
        $finish;
    end

endmodule
